/* design/costas_carrier_recovery_core_macros.svh */
// assertion macros for the costas carrier recovery core
`ifndef COSTAS_CARRIER_RECOVERY_CORE_MACROS_SVH
`define COSTAS_CARRIER_RECOVERY_CORE_MACROS_SVH

`ifndef SYNTH
`define CCR_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ccr assertion failed");
`define CCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccr assertion failed");
`else
`define CCR_ASSERT(label, expr)
`define CCR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/ccr_pkg.sv */
package ccr_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int SINCOS_ADDR_BITS = 10;
  localparam int FRAC             = SAMPLE_BITS - 1;
  localparam int QTR_BITS         = SINCOS_ADDR_BITS - 2;
  localparam int QTR_DEPTH        = 1 << QTR_BITS;
  localparam int GAIN_W           = 16;
  localparam int FREQ_W           = 32;
  localparam int PHASE_W          = 32;
  localparam int ERR_W            = SAMPLE_BITS + 1;
  localparam int OPA_W            = (SAMPLE_BITS > GAIN_W + 1) ? SAMPLE_BITS : GAIN_W + 1;
  localparam int PROD_W           = OPA_W + ERR_W;
  localparam int SUM_W            = PROD_W + 1;
  localparam int NF_W             = ((PROD_W > FREQ_W) ? PROD_W : FREQ_W) + 1;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DETECTOR_ORDER = CFG_IDX_W'(4);

  localparam logic [GAIN_W-1:0]        PHASE_GAIN_RST = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0]        FREQ_GAIN_RST  = GAIN_W'(32);
  localparam logic signed [FREQ_W-1:0] MAX_FREQ_RST   = FREQ_W'(268435456);
  localparam logic signed [FREQ_W-1:0] MIN_FREQ_RST   = FREQ_W'(-268435456);
  localparam logic                     ORDER_RST      = 1'b1;

  // detector order codes
  localparam logic ORDER_BPSK = 1'b0;
  localparam logic ORDER_QPSK = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ERR_W-1:0]       err_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic [FRAC-1:0]               qtr_rom_t [QTR_DEPTH];

  typedef struct packed {
    logic load;
    logic rot1;
    logic rot2;
    logic rot3;
    logic err_mul;
    logic err_fix;
    logic gain;
    logic upd;
  } ccr_cmd_t;

  localparam longint TAYLOR_Q30 [5] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306, -64'sd5026995, 64'sd172272
  };

  // quarter-wave sine amplitude at step k of QTR_DEPTH, elaboration only
  function automatic longint sin_amp(input longint k);
    longint t;
    longint t2;
    longint p;
    longint s;
    longint v;
    int     j;
    t  = k <<< (32 - SINCOS_ADDR_BITS);
    t2 = (t * t) >>> 30;
    p  = TAYLOR_Q30[4];
    for (j = 3; j >= 0; j--) begin
      p = TAYLOR_Q30[j] + ((p * t2) >>> 30);
    end
    s = (p * t) >>> 30;
    v = (s + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    if (v > (longint'(1) <<< FRAC) - 1) begin
      v = (longint'(1) <<< FRAC) - 1;
    end
    if (v < 0) begin
      v = 0;
    end
    return v;
  endfunction

  function automatic qtr_rom_t build_qtr();
    qtr_rom_t tab;
    longint   v;
    int       k;
    for (k = 0; k < QTR_DEPTH; k++) begin
      v      = sin_amp(longint'(k));
      tab[k] = v[FRAC-1:0];
    end
    return tab;
  endfunction

  localparam qtr_rom_t          QTR_ROM    = build_qtr();
  localparam longint            QTR_FULL_L = sin_amp(longint'(QTR_DEPTH));
  localparam logic [FRAC-1:0]   QTR_FULL   = QTR_FULL_L[FRAC-1:0];

  // full-circle sine from the quarter table
  function automatic sample_t rom_lookup(input logic [SINCOS_ADDR_BITS-1:0] a);
    logic [1:0]          q;
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS-1:0] idx;
    logic [FRAC-1:0]     mag;
    sample_t             v;
    q   = a[SINCOS_ADDR_BITS-1 -: 2];
    r   = a[QTR_BITS-1:0];
    idx = ~r + QTR_BITS'(1);
    // falling quarters read the table mirrored; their first step is the peak
    if (q[0] && (r == '0)) begin
      mag = QTR_FULL;
    end else if (q[0]) begin
      mag = QTR_ROM[idx];
    end else begin
      mag = QTR_ROM[r];
    end
    v = {1'b0, mag};
    return q[1] ? -v : v;
  endfunction

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(longint'(1) <<< (FRAC - 1));
  localparam logic signed [SUM_W-1:0] SMP_MAX  = SUM_W'((longint'(1) <<< FRAC) - 1);
  localparam logic signed [SUM_W-1:0] SMP_MIN  = SUM_W'(-(longint'(1) <<< FRAC));

  function automatic sample_t sat_round(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] y;
    y = (x + RND_HALF) >>> FRAC;
    if (y > SMP_MAX) begin
      return {1'b0, {FRAC{1'b1}}};
    end else if (y < SMP_MIN) begin
      return {1'b1, {FRAC{1'b0}}};
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  localparam prod_t ERR_HI = PROD_W'(longint'(1) <<< FRAC);
  localparam prod_t ERR_LO = PROD_W'(-(longint'(1) <<< FRAC));

  function automatic err_t err_clamp(input prod_t x);
    if (x > ERR_HI) begin
      return ERR_HI[ERR_W-1:0];
    end else if (x < ERR_LO) begin
      return ERR_LO[ERR_W-1:0];
    end
    return x[ERR_W-1:0];
  endfunction

endpackage

/* design/ccr_ctrl.sv */
module ccr_ctrl
  import ccr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  output ccr_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ROT1  = 8'b0000_0010,
    ST_ROT2  = 8'b0000_0100,
    ST_ROT3  = 8'b0000_1000,
    ST_ERR   = 8'b0001_0000,
    ST_CLAMP = 8'b0010_0000,
    ST_GAIN  = 8'b0100_0000,
    ST_UPD   = 8'b1000_0000
  } ccr_state_t;

  ccr_state_t state_r;
  ccr_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROT1;
        end
      end
      ST_ROT1: begin
        cmd.rot1  = 1'b1;
        state_nxt = ST_ROT2;
      end
      ST_ROT2: begin
        cmd.rot2  = 1'b1;
        state_nxt = ST_ROT3;
      end
      ST_ROT3: begin
        cmd.rot3  = 1'b1;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_mul = 1'b1;
        state_nxt   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.err_fix = 1'b1;
        state_nxt   = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // loop state and result register move together, only once the slot is free
        if (out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/ccr_datapath.sv */
module ccr_datapath
  import ccr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccr_cmd_t                    cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q,
  output logic signed [FREQ_W-1:0]    out_freq_estimate
);

  // configuration and loop state
  logic [GAIN_W-1:0]        phase_gain_r, phase_gain_nxt;
  logic [GAIN_W-1:0]        freq_gain_r, freq_gain_nxt;
  logic signed [FREQ_W-1:0] max_freq_r, max_freq_nxt;
  logic signed [FREQ_W-1:0] min_freq_r, min_freq_nxt;
  logic                     order_r, order_nxt;
  logic [PHASE_W-1:0]       phase_acc_r, phase_acc_nxt;
  logic signed [FREQ_W-1:0] freq_acc_r, freq_acc_nxt;

  // working registers
  sample_t xi_r, xi_nxt;
  sample_t xq_r, xq_nxt;
  sample_t sn_r, sn_nxt;
  sample_t cs_r, cs_nxt;
  prod_t   pa_r, pa_nxt;
  prod_t   pb_r, pb_nxt;
  sample_t oi_r, oi_nxt;
  sample_t oq_r, oq_nxt;
  err_t    err_r, err_nxt;
  sample_t res_i_r, res_i_nxt;
  sample_t res_q_r, res_q_nxt;

  logic [SINCOS_ADDR_BITS-1:0] rom_addr;
  logic signed [OPA_W-1:0]     ma_x, mb_x;
  logic signed [ERR_W-1:0]     ma_y, mb_y;
  prod_t                       prod_a, prod_b;
  logic signed [SUM_W-1:0]     rot_sum;
  sample_t                     rot_val;
  err_t                        t_q, t_i;
  logic signed [ERR_W:0]       qpsk_diff;
  err_t                        err_val;
  logic signed [NF_W-1:0]      nf;
  logic signed [NF_W-1:0]      pb_wide;
  logic signed [FREQ_W-1:0]    nf_clamped;
  logic signed [FREQ_W-1:0]    mid_a, mid_b;
  logic signed [FREQ_W:0]      mid_sum;

  assign rom_addr = phase_acc_r[PHASE_W-1 -: SINCOS_ADDR_BITS];

  // two shared multipliers
  always_comb begin
    priority if (cmd.rot1) begin
      ma_x = OPA_W'(xi_r);
      ma_y = ERR_W'(cs_r);
      mb_x = OPA_W'(xq_r);
      mb_y = ERR_W'(sn_r);
    end else if (cmd.rot2) begin
      ma_x = OPA_W'(xq_r);
      ma_y = ERR_W'(cs_r);
      mb_x = OPA_W'(xi_r);
      mb_y = ERR_W'(sn_r);
    end else if (cmd.err_mul) begin
      ma_x = OPA_W'(oi_r);
      ma_y = ERR_W'(oq_r);
      mb_x = '0;
      mb_y = '0;
    end else if (cmd.gain) begin
      ma_x = OPA_W'({1'b0, freq_gain_r});
      ma_y = err_r;
      mb_x = OPA_W'({1'b0, phase_gain_r});
      mb_y = err_r;
    end else begin
      ma_x = '0;
      ma_y = '0;
      mb_x = '0;
      mb_y = '0;
    end
  end

  assign prod_a = ma_x * ma_y;
  assign prod_b = mb_x * mb_y;

  // rotation adder: i uses the sum, q the difference
  assign rot_sum = cmd.rot3 ? (SUM_W'(pa_r) - SUM_W'(pb_r)) : (SUM_W'(pa_r) + SUM_W'(pb_r));
  assign rot_val = sat_round(rot_sum);

  // qpsk detector, zero counts as negative
  assign t_q       = (oi_r > 0) ? ERR_W'(oq_r) : -ERR_W'(oq_r);
  assign t_i       = (oq_r > 0) ? ERR_W'(oi_r) : -ERR_W'(oi_r);
  assign qpsk_diff = (ERR_W + 1)'(t_q) - (ERR_W + 1)'(t_i);
  assign err_val   = (order_r == ORDER_BPSK) ? err_clamp(pa_r >>> FRAC)
                                             : err_clamp(PROD_W'(qpsk_diff));

  // loop update; phase takes the unclamped frequency
  assign nf      = NF_W'(freq_acc_r) + NF_W'(pa_r);
  assign pb_wide = NF_W'(pb_r);

  always_comb begin
    if (nf > NF_W'(max_freq_r)) begin
      nf_clamped = max_freq_r;
    end else if (nf < NF_W'(min_freq_r)) begin
      nf_clamped = min_freq_r;
    end else begin
      nf_clamped = nf[FREQ_W-1:0];
    end
  end

  // midpoint reload after a clamp write
  assign mid_a   = (cfg_index == REG_MAX_FREQ) ? $signed(cfg_data[FREQ_W-1:0]) : max_freq_r;
  assign mid_b   = (cfg_index == REG_MIN_FREQ) ? $signed(cfg_data[FREQ_W-1:0]) : min_freq_r;
  assign mid_sum = (FREQ_W + 1)'(mid_a) + (FREQ_W + 1)'(mid_b);

  always_comb begin
    phase_gain_nxt = phase_gain_r;
    freq_gain_nxt  = freq_gain_r;
    max_freq_nxt   = max_freq_r;
    min_freq_nxt   = min_freq_r;
    order_nxt      = order_r;
    phase_acc_nxt  = phase_acc_r;
    freq_acc_nxt   = freq_acc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_GAIN:     phase_gain_nxt = cfg_data[GAIN_W-1:0];
        REG_FREQ_GAIN:      freq_gain_nxt  = cfg_data[GAIN_W-1:0];
        REG_MAX_FREQ: begin
          max_freq_nxt = cfg_data[FREQ_W-1:0];
          freq_acc_nxt = mid_sum[FREQ_W:1];
        end
        REG_MIN_FREQ: begin
          min_freq_nxt = cfg_data[FREQ_W-1:0];
          freq_acc_nxt = mid_sum[FREQ_W:1];
        end
        REG_DETECTOR_ORDER: order_nxt = cfg_data[0];
        default: ;
      endcase
    end
    if (cmd.upd) begin
      phase_acc_nxt = phase_acc_r + nf[PHASE_W-1:0] + pb_wide[PHASE_W-1:0];
      freq_acc_nxt  = nf_clamped;
    end
  end

  always_comb begin
    xi_nxt    = xi_r;
    xq_nxt    = xq_r;
    sn_nxt    = sn_r;
    cs_nxt    = cs_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    oi_nxt    = oi_r;
    oq_nxt    = oq_r;
    err_nxt   = err_r;
    res_i_nxt = res_i_r;
    res_q_nxt = res_q_r;
    if (cmd.load) begin
      xi_nxt = in_i;
      xq_nxt = in_q;
      sn_nxt = rom_lookup(rom_addr);
      cs_nxt = rom_lookup(rom_addr + SINCOS_ADDR_BITS'(QTR_DEPTH));
    end
    if (cmd.rot1 || cmd.rot2 || cmd.err_mul || cmd.gain) begin
      pa_nxt = prod_a;
    end
    if (cmd.rot1 || cmd.rot2 || cmd.gain) begin
      pb_nxt = prod_b;
    end
    if (cmd.rot2) begin
      oi_nxt = rot_val;
    end
    if (cmd.rot3) begin
      oq_nxt = rot_val;
    end
    if (cmd.err_fix) begin
      err_nxt = err_val;
    end
    if (cmd.upd) begin
      res_i_nxt = oi_r;
      res_q_nxt = oq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_gain_r <= PHASE_GAIN_RST;
      freq_gain_r  <= FREQ_GAIN_RST;
      max_freq_r   <= MAX_FREQ_RST;
      min_freq_r   <= MIN_FREQ_RST;
      order_r      <= ORDER_RST;
      phase_acc_r  <= '0;
      freq_acc_r   <= '0;
    end else begin
      phase_gain_r <= phase_gain_nxt;
      freq_gain_r  <= freq_gain_nxt;
      max_freq_r   <= max_freq_nxt;
      min_freq_r   <= min_freq_nxt;
      order_r      <= order_nxt;
      phase_acc_r  <= phase_acc_nxt;
      freq_acc_r   <= freq_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xi_r    <= xi_nxt;
    xq_r    <= xq_nxt;
    sn_r    <= sn_nxt;
    cs_r    <= cs_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    oi_r    <= oi_nxt;
    oq_r    <= oq_nxt;
    err_r   <= err_nxt;
    res_i_r <= res_i_nxt;
    res_q_r <= res_q_nxt;
  end

  assign out_i             = res_i_r;
  assign out_q             = res_q_r;
  assign out_freq_estimate = freq_acc_r;

endmodule

/* design/costas_carrier_recovery_core.sv */
// costas carrier recovery core, bpsk/qpsk detector, one result per sample
// each taken sample steps through rot1, rot2, rot3, err, clamp, gain and upd; upd registers
//   the result once the last one is taken; no new sample is taken until upd is done, as the
//   phase recurrence runs through the two shared multipliers (rotate, detect, gains)
// reset: synchronous, rst_n low; gains, clamps and order to defaults, phase 0,
//   frequency at the midpoint of the default clamps; no clearing pass
`include "costas_carrier_recovery_core_macros.svh"

module costas_carrier_recovery_core
  import ccr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q,
  output logic signed [FREQ_W-1:0]      out_freq_estimate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  ccr_cmd_t cmd;
  logic     cfg_we;

  // registers take a request in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ccr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ccr_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_i              (in_i),
    .in_q              (in_q),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_i             (out_i),
    .out_q             (out_q),
    .out_freq_estimate (out_freq_estimate)
  );

  `CCR_ASSERT_NEXT(a_accept_blocks_input, in_valid && !in_stall, in_stall)
  `CCR_ASSERT_NEXT(a_update_shows_result, cmd.upd, out_valid)
  `CCR_ASSERT(a_single_command, $onehot0(cmd))
  `CCR_ASSERT(a_no_result_overwrite, !cmd.upd || !out_valid || !out_stall)

endmodule

/* verif/tb_costas_carrier_recovery_core.sv */
module tb_costas_carrier_recovery_core;
  import ccr_pkg::*;

  localparam int     DIR_N        = 31;
  localparam int     RND_PHASES   = 15;
  localparam int     PHASE_ITEMS  = 70;
  localparam int     SETTLE       = 16;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     NUM_REGS     = int'(REG_DETECTOR_ORDER) + 1;
  localparam int     IDX_TOP      = (1 << CFG_IDX_W) - 1;
  localparam sample_t SMP_TOP     = {1'b0, {FRAC{1'b1}}};
  localparam sample_t SMP_BOT     = {1'b1, {FRAC{1'b0}}};
  localparam longint SINE_COEF [5] = '{1686629713, -693598668, 85569306, -5026995, 172272};

  typedef struct {
    sample_t                   ri;
    sample_t                   rq;
    logic signed [FREQ_W-1:0]  rf;
  } rot_result_t;

  typedef struct {
    bit                        is_cfg;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    sample_t                   si;
    sample_t                   sq;
    bit                        known;
    sample_t                   ei;
    sample_t                   eq;
    logic signed [FREQ_W-1:0]  ef;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  sample_t                      in_i = '0;
  sample_t                      in_q = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  sample_t                      out_i;
  sample_t                      out_q;
  logic signed [FREQ_W-1:0]     out_freq_estimate;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  // loop model state and register copies
  logic [PHASE_W-1:0]           loop_phase;
  longint                       loop_freq;
  logic [GAIN_W-1:0]            loop_pgain;
  logic [GAIN_W-1:0]            loop_fgain;
  longint                       loop_max;
  longint                       loop_min;
  logic                         loop_order;

  rot_result_t                  pending_rot [$];
  dir_row_t                     dir_tab [DIR_N];
  int                           fail_cnt = 0;
  int                           idle_mode = 0;
  bit                           hold_req = 1'b0;
  bit                           hold_done = 1'b0;
  int                           hold_left = 0;

  costas_carrier_recovery_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_i              (in_i),
    .in_q              (in_q),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_i             (out_i),
    .out_q             (out_q),
    .out_freq_estimate (out_freq_estimate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // sine of a rom address, taylor series in q30, scaled to the sample format
  function automatic longint taylor_sine(input logic [SINCOS_ADDR_BITS-1:0] a);
    logic [1:0] quad;
    longint     t;
    longint     t2;
    longint     p;
    longint     s;
    longint     v;
    int         k;
    quad = a[SINCOS_ADDR_BITS-1 -: 2];
    t = longint'(a[QTR_BITS-1:0]) <<< (32 - SINCOS_ADDR_BITS);
    if (quad[0]) begin
      t = (longint'(1) <<< 30) - t;
    end
    t2 = (t * t) >>> 30;
    p = SINE_COEF[4];
    for (k = 3; k >= 0; k--) begin
      p = SINE_COEF[k] + ((p * t2) >>> 30);
    end
    s = (p * t) >>> 30;
    v = (s + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    if (v > (longint'(1) <<< FRAC) - 1) begin
      v = (longint'(1) <<< FRAC) - 1;
    end
    if (v < 0) begin
      v = 0;
    end
    return quad[1] ? -v : v;
  endfunction

  function automatic longint sat_smp(input longint x);
    if (x > (longint'(1) <<< FRAC) - 1) begin
      return (longint'(1) <<< FRAC) - 1;
    end else if (x < -(longint'(1) <<< FRAC)) begin
      return -(longint'(1) <<< FRAC);
    end
    return x;
  endfunction

  // one loop iteration: derotate, detect, update frequency and phase
  function automatic rot_result_t track_sample(input sample_t si, input sample_t sq);
    logic [SINCOS_ADDR_BITS-1:0] addr;
    longint      sn;
    longint      cs;
    longint      oi;
    longint      oq;
    longint      err;
    longint      nf;
    longint      lim;
    longint      half;
    rot_result_t r;
    addr = loop_phase[PHASE_W-1 -: SINCOS_ADDR_BITS];
    sn = taylor_sine(addr);
    cs = taylor_sine(addr + SINCOS_ADDR_BITS'(QTR_DEPTH));
    half = longint'(1) <<< (FRAC - 1);
    lim = longint'(1) <<< FRAC;
    oi = sat_smp((longint'(si) * cs + longint'(sq) * sn + half) >>> FRAC);
    oq = sat_smp((longint'(sq) * cs - longint'(si) * sn + half) >>> FRAC);
    if (loop_order == ORDER_BPSK) begin
      err = (oi * oq) >>> FRAC;
    end else begin
      // zero counts as negative on both slicers
      err = ((oi > 0) ? oq : -oq) - ((oq > 0) ? oi : -oi);
    end
    if (err > lim) begin
      err = lim;
    end else if (err < -lim) begin
      err = -lim;
    end
    nf = loop_freq + longint'(loop_fgain) * err;
    // phase takes the unclamped frequency, modulo 2^32
    loop_phase = loop_phase + 32'(nf) + 32'(longint'(loop_pgain) * err);
    if (nf > loop_max) begin
      nf = loop_max;
    end else if (nf < loop_min) begin
      nf = loop_min;
    end
    loop_freq = nf;
    r.ri = sample_t'(oi);
    r.rq = sample_t'(oq);
    r.rf = FREQ_W'(loop_freq);
    return r;
  endfunction

  function automatic bit gap_now(input bit rx);
    int pct;
    case (idle_mode)
      0:       pct = rx ? 58 : 9;
      1:       pct = rx ? 9 : 58;
      default: pct = 0;
    endcase
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic void check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // enter and leave at a falling edge
  task automatic push_sample(input sample_t si, input sample_t sq, input bit known,
                             input rot_result_t typed);
    rot_result_t pred;
    while (gap_now(1'b0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_i <= si;
    in_q <= sq;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pred = track_sample(si, sq);
    pending_rot.push_back(known ? typed : pred);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_rot.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_PHASE_GAIN:     loop_pgain = data[GAIN_W-1:0];
      REG_FREQ_GAIN:      loop_fgain = data[GAIN_W-1:0];
      REG_MAX_FREQ: begin
        loop_max = longint'($signed(data));
        loop_freq = (loop_max + loop_min) >>> 1;
      end
      REG_MIN_FREQ: begin
        loop_min = longint'($signed(data));
        loop_freq = (loop_max + loop_min) >>> 1;
      end
      REG_DETECTOR_ORDER: loop_order = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] v;
    int                    sel;
    v = $urandom();
    sel = $urandom_range(3, 0);
    case (idx)
      REG_PHASE_GAIN, REG_FREQ_GAIN: begin
        case (sel)
          0:       v[GAIN_W-1:0] = '0;
          1:       v[GAIN_W-1:0] = '1;
          2:       v[GAIN_W-1:0] = GAIN_W'($urandom_range(4096, 0));
          default: ;
        endcase
      end
      REG_MAX_FREQ: begin
        case (sel)
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = $urandom_range(32'h2000_0000, 0);
          default: ;
        endcase
      end
      REG_MIN_FREQ: begin
        case (sel)
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = -$urandom_range(32'h2000_0000, 0);
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic program_phase();
    int j;
    int rot;
    rot = $urandom_range(NUM_REGS - 1, 0);
    for (j = 0; j < NUM_REGS; j++) begin
      write_reg(CFG_IDX_W'((j + rot) % NUM_REGS), pick_reg_value(CFG_IDX_W'((j + rot) % NUM_REGS)));
    end
    if ($urandom_range(3, 0) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(IDX_TOP, NUM_REGS)), $urandom());
    end
  endtask

  function automatic sample_t corner_val();
    case ($urandom_range(4, 0))
      0:       return SMP_BOT;
      1:       return SMP_TOP;
      2:       return sample_t'(-1);
      3:       return sample_t'(1);
      default: return '0;
    endcase
  endfunction

  task automatic pick_sample(output sample_t si, output sample_t sq);
    int sel;
    int amp;
    int noise_i;
    int noise_q;
    sel = $urandom_range(9, 0);
    amp = $urandom_range(30000, 4000);
    noise_i = int'($urandom_range(4000, 0)) - 2000;
    noise_q = int'($urandom_range(4000, 0)) - 2000;
    if (sel == 0) begin
      si = corner_val();
      sq = corner_val();
    end else if (sel <= 2) begin
      si = sample_t'($urandom());
      sq = sample_t'($urandom());
    end else begin
      // constellation point with noise, matched to the detector in use
      si = sample_t'(($urandom_range(1, 0) ? amp : -amp) + noise_i);
      if (loop_order == ORDER_BPSK) begin
        sq = sample_t'(noise_q);
      end else begin
        sq = sample_t'(($urandom_range(1, 0) ? amp : -amp) + noise_q);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= gap_now(1'b1);
    end
  end

  always @(posedge clk) begin : result_check
    rot_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rot.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, expected none, actual i=%0d q=%0d f=%0d",
                 $time, out_i, out_q, out_freq_estimate);
      end else begin
        want = pending_rot.pop_front();
        check_field("out_i", want.ri, out_i);
        check_field("out_q", want.rq, out_q);
        check_field("out_freq_estimate", want.rf, out_freq_estimate);
      end
    end
  end

  initial begin : stim
    int          n;
    int          ph;
    int          k;
    sample_t     si;
    sample_t     sq;
    rot_result_t typed;
    rot_result_t blank;
    blank = '{default: 0};
    loop_phase = '0;
    loop_pgain = PHASE_GAIN_RST;
    loop_fgain = FREQ_GAIN_RST;
    loop_max = longint'(MAX_FREQ_RST);
    loop_min = longint'(MIN_FREQ_RST);
    loop_order = ORDER_RST;
    loop_freq = (loop_max + loop_min) >>> 1;
    // cfg, index, data, i, q, known, exp i, exp q, exp freq
    dir_tab = '{
      // at reset: phase zero, cosine full scale, frequency zero
      '{1'b0, '0, '0,      0,      0, 1'b1,      0,      0, 0},
      '{1'b0, '0, '0,      0,      0, 1'b1,      0,      0, 0},
      '{1'b0, '0, '0, -32768, -32768, 1'b1, -32767, -32767, 0},
      '{1'b0, '0, '0,  32767,  32767, 1'b1,  32766,  32766, 0},
      '{1'b0, '0, '0,  32767, -32768, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0, -32768,  32767, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,      0,  12000, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  12000,      0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,      0, -12000, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,      1,     -1, 1'b0, 0, 0, 0},
      '{1'b1, REG_DETECTOR_ORDER, {{(CFG_DATA_W-1){1'b1}}, ORDER_BPSK}, 0, 0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  32767,  32767, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0, -32768,  32767, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  20000, -20000, 1'b0, 0, 0, 0},
      '{1'b1, REG_PHASE_GAIN, 32'hFFFF_FFFF, 0, 0, 1'b0, 0, 0, 0},
      '{1'b1, REG_FREQ_GAIN,  32'hFFFF_FFFF, 0, 0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  32767, -32768, 1'b0, 0, 0, 0},
      '{1'b1, REG_MAX_FREQ,   32'h7FFF_FFFF, 0, 0, 1'b0, 0, 0, 0},
      '{1'b1, REG_MIN_FREQ,   32'h8000_0000, 0, 0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0, -32768, -32768, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  32767,      0, 1'b0, 0, 0, 0},
      '{1'b1, REG_DETECTOR_ORDER, {{(CFG_DATA_W-1){1'b0}}, ORDER_QPSK}, 0, 0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  32767, -32768, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0, -32768,      0, 1'b0, 0, 0, 0},
      // clamps crossed: min above max
      '{1'b1, REG_MIN_FREQ,   32'h1000_0000, 0, 0, 1'b0, 0, 0, 0},
      '{1'b1, REG_MAX_FREQ,   32'hF000_0000, 0, 0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,  25000,   5000, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0, -25000,   5000, 1'b0, 0, 0, 0},
      '{1'b1, CFG_IDX_W'(NUM_REGS), 32'hA5A5_5A5A, 0, 0, 1'b0, 0, 0, 0},
      '{1'b1, REG_PHASE_GAIN, 32'h0000_0000, 0, 0, 1'b0, 0, 0, 0},
      '{1'b0, '0, '0,   9000,  -9000, 1'b0, 0, 0, 0}
    };
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < DIR_N; n++) begin
      if (dir_tab[n].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[n].idx, dir_tab[n].data);
      end else begin
        typed.ri = dir_tab[n].ei;
        typed.rq = dir_tab[n].eq;
        typed.rf = dir_tab[n].ef;
        push_sample(dir_tab[n].si, dir_tab[n].sq, dir_tab[n].known, typed);
      end
    end

    for (ph = 0; ph < RND_PHASES; ph++) begin
      wait_idle();
      idle_mode <= (ph < 5) ? 0 : ((ph < 10) ? 1 : 2);
      program_phase();
      if (ph == 2) begin
        hold_req <= 1'b1;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick_sample(si, sq);
        push_sample(si, sq, 1'b0, blank);
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
